### hdl/akf_pkg.sv
package akf_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned CFG_W  = 31;
  localparam int unsigned DT_W   = 17;

  localparam logic [IDX_W-1:0] REG_DT  = 3'd0;
  localparam logic [IDX_W-1:0] REG_SZ  = 3'd1;
  localparam logic [IDX_W-1:0] REG_QAA = 3'd2;
  localparam logic [IDX_W-1:0] REG_QAB = 3'd3;
  localparam logic [IDX_W-1:0] REG_QBA = 3'd4;
  localparam logic [IDX_W-1:0] REG_QBB = 3'd5;

  localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

  // scratch register file addresses
  typedef enum logic [4:0] {
    R_X0, R_X1, R_U, R_Y, R_NDT, R_DT, R_P00, R_P01, R_P10, R_P11,
    R_SZ, R_QAA, R_QAB, R_QBA, R_QBB, R_ZERO,
    R_T0, R_T1, R_INN, R_S, R_AP00, R_AP01, R_K0, R_K1,
    R_AT00, R_AT10, R_KC00, R_KC01, R_KC10, R_KC11, R_T2
  } reg_t;

  typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL, OP_DIV} op_t;

  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_OUT} state_t;

  typedef struct packed {
    logic load;
    logic go;
    op_t  op;
    reg_t src_a;
    reg_t src_b;
    reg_t dst;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic s_pos;
  } sts_t;

  typedef struct packed {
    op_t  op;
    reg_t a;
    reg_t b;
    reg_t d;
  } uop_t;

  localparam int unsigned NUM_UOPS = 36;

  // microprogram of one filter step; step index selects one operation
  function automatic uop_t uop(input logic [5:0] i);
    uop_t u;
    unique case (i)
      6'd0:  u = '{OP_MUL, R_NDT, R_X1, R_T0};
      6'd1:  u = '{OP_MUL, R_DT, R_U, R_T1};
      6'd2:  u = '{OP_ADD, R_T0, R_T1, R_T0};
      6'd3:  u = '{OP_ADD, R_X0, R_T0, R_X0};
      6'd4:  u = '{OP_SUB, R_Y, R_X0, R_INN};
      6'd5:  u = '{OP_ADD, R_P00, R_SZ, R_S};
      6'd6:  u = '{OP_MUL, R_NDT, R_P10, R_T0};
      6'd7:  u = '{OP_ADD, R_P00, R_T0, R_AP00};
      6'd8:  u = '{OP_MUL, R_NDT, R_P11, R_T0};
      6'd9:  u = '{OP_ADD, R_P01, R_T0, R_AP01};
      6'd10: u = '{OP_DIV, R_AP00, R_S, R_K0};
      6'd11: u = '{OP_DIV, R_P10, R_S, R_K1};
      6'd12: u = '{OP_MUL, R_K0, R_INN, R_T0};
      6'd13: u = '{OP_ADD, R_X0, R_T0, R_X0};
      6'd14: u = '{OP_MUL, R_K1, R_INN, R_T0};
      6'd15: u = '{OP_ADD, R_X1, R_T0, R_X1};
      6'd16: u = '{OP_MUL, R_AP01, R_NDT, R_T0};
      6'd17: u = '{OP_ADD, R_AP00, R_T0, R_AT00};
      6'd18: u = '{OP_MUL, R_P11, R_NDT, R_T0};
      6'd19: u = '{OP_ADD, R_P10, R_T0, R_AT10};
      6'd20: u = '{OP_MUL, R_K0, R_P00, R_T0};
      6'd21: u = '{OP_MUL, R_K0, R_P01, R_KC01};
      6'd22: u = '{OP_MUL, R_KC01, R_NDT, R_T1};
      6'd23: u = '{OP_ADD, R_T0, R_T1, R_KC00};
      6'd24: u = '{OP_MUL, R_K1, R_P00, R_T0};
      6'd25: u = '{OP_MUL, R_K1, R_P01, R_KC11};
      6'd26: u = '{OP_MUL, R_KC11, R_NDT, R_T1};
      6'd27: u = '{OP_ADD, R_T0, R_T1, R_KC10};
      6'd28: u = '{OP_SUB, R_AT00, R_KC00, R_T0};
      6'd29: u = '{OP_ADD, R_T0, R_QAA, R_T2};
      6'd30: u = '{OP_SUB, R_AP01, R_KC01, R_T0};
      6'd31: u = '{OP_ADD, R_T0, R_QAB, R_P01};
      6'd32: u = '{OP_SUB, R_AT10, R_KC10, R_T0};
      6'd33: u = '{OP_ADD, R_T0, R_QBA, R_P10};
      6'd34: u = '{OP_SUB, R_P11, R_KC11, R_T0};
      6'd35: u = '{OP_ADD, R_T0, R_QBB, R_P11};
      default: u = '{OP_ADD, R_ZERO, R_ZERO, R_T1};
    endcase
    return u;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat(input logic signed [65:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > 66'(SAT_MAX)) r = SAT_MAX;
    else if (v < 66'(SAT_MIN)) r = SAT_MIN;
    else r = v[DATA_W-1:0];
    return r;
  endfunction

endpackage

### hdl/akf_ctrl.sv
module akf_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output akf_pkg::cmd_t cmd,
  input  akf_pkg::sts_t sts
);

  akf_pkg::state_t state_r, state_nxt;
  logic [5:0] pc_r, pc_nxt;
  akf_pkg::uop_t u;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= akf_pkg::ST_IDLE;
      pc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
    end
  end

  // sequencer: one micro-op issued, then wait for unit
  always_comb begin
    u         = akf_pkg::uop(pc_r);
    state_nxt = state_r;
    pc_nxt    = pc_r;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    cmd       = '{load: 1'b0, go: 1'b0, op: u.op, src_a: u.a, src_b: u.b,
                  dst: u.d, commit: 1'b0};
    unique case (state_r)
      akf_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          pc_nxt    = '0;
          state_nxt = akf_pkg::ST_ISSUE;
        end
      end
      akf_pkg::ST_ISSUE: begin
        cmd.go    = 1'b1;
        state_nxt = akf_pkg::ST_WAIT;
      end
      akf_pkg::ST_WAIT: begin
        if (sts.done) begin
          if (pc_r == 6'(akf_pkg::NUM_UOPS - 1)) begin
            cmd.commit = 1'b1;
            state_nxt  = akf_pkg::ST_OUT;
          end else begin
            pc_nxt    = pc_r + 6'd1;
            state_nxt = akf_pkg::ST_ISSUE;
          end
        end
      end
      akf_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) state_nxt = akf_pkg::ST_IDLE;
      end
      default: state_nxt = akf_pkg::ST_IDLE;
    endcase
  end

  // a word is only taken while idle
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != akf_pkg::ST_IDLE) |-> in_stall)
    else $error("input taken while busy");
  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r < 6'(akf_pkg::NUM_UOPS))
    else $error("micro pc out of range");
  a_out_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.commit))
    else $error("result shown without commit");

endmodule

### hdl/akf_dp.sv
module akf_dp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  akf_pkg::cmd_t        cmd,
  output akf_pkg::sts_t        sts,
  input  logic signed [31:0]   in_gyro_rate,
  input  logic signed [31:0]   in_accel_angle,
  input  logic [16:0]          dt,
  input  logic [30:0]          sz,
  input  logic [30:0]          qaa,
  input  logic [30:0]          qab,
  input  logic [30:0]          qba,
  input  logic [30:0]          qbb,
  output logic signed [31:0]   angle_estimate,
  output logic                 gain_fault
);

  localparam int DW = 32;
  localparam int NW = DW + FRAC_BITS + 1;   // scaled numerator magnitude bits

  logic signed [DW-1:0] rf_r [32];
  logic signed [DW-1:0] a_r, b_r, res_r;
  akf_pkg::op_t op_r;
  akf_pkg::reg_t dst_r;
  logic busy_r, done_r, fault_r;
  logic signed [63:0] prod_r;
  logic mul_ph_r;
  // divider
  logic [NW-1:0] quo_r;
  logic [NW:0]   rem_r;
  logic [NW-1:0] num_r;
  logic [5:0]    cnt_r;
  logic          neg_r;
  logic [DW-1:0] den_r;

  logic signed [DW-1:0] opa, opb, s_val;
  logic signed [63:0] pr;
  logic [63:0] pneg;
  logic signed [65:0] mres;
  logic [NW:0] rtry;
  logic signed [65:0] dres;

  assign opa   = rf_r[cmd.src_a];
  assign opb   = rf_r[cmd.src_b];
  assign s_val = rf_r[akf_pkg::R_S];
  assign sts.done  = done_r;
  assign sts.s_pos = (s_val > 0);

  // multiply result with floor shift, divider trial subtract and signed quotient
  always_comb begin
    pr   = prod_r;
    pneg = 64'(-pr);
    if (pr >= 0) mres = 66'(pr >>> FRAC_BITS);
    else mres = -66'((pneg + 64'((64'd1 << FRAC_BITS) - 1)) >> FRAC_BITS);
    rtry = {rem_r[NW-1:0], num_r[NW-1]} - {1'b0, den_r};
    dres = neg_r ? -66'(quo_r) : 66'(quo_r);
  end

  // register file, shared ALU, multi-cycle multiplier and divider
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      rf_r[akf_pkg::R_X0]  <= '0;
      rf_r[akf_pkg::R_X1]  <= '0;
      rf_r[akf_pkg::R_P00] <= 32'sd66;
      rf_r[akf_pkg::R_P01] <= 32'sd197;
      rf_r[akf_pkg::R_P10] <= 32'sd197;
      rf_r[akf_pkg::R_P11] <= 32'sd197;
      rf_r[akf_pkg::R_T2]  <= '0;
      angle_estimate <= '0;
      gain_fault     <= 1'b0;
      fault_r        <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (cmd.load) begin
        rf_r[akf_pkg::R_U]    <= in_gyro_rate;
        rf_r[akf_pkg::R_Y]    <= in_accel_angle;
        rf_r[akf_pkg::R_DT]   <= $signed({15'd0, dt});
        rf_r[akf_pkg::R_NDT]  <= -$signed({15'd0, dt});
        rf_r[akf_pkg::R_SZ]   <= $signed({1'b0, sz});
        rf_r[akf_pkg::R_QAA]  <= $signed({1'b0, qaa});
        rf_r[akf_pkg::R_QAB]  <= $signed({1'b0, qab});
        rf_r[akf_pkg::R_QBA]  <= $signed({1'b0, qba});
        rf_r[akf_pkg::R_QBB]  <= $signed({1'b0, qbb});
        rf_r[akf_pkg::R_ZERO] <= '0;
      end
      if (cmd.go) begin
        a_r <= opa; b_r <= opb; op_r <= cmd.op; dst_r <= cmd.dst;
        busy_r <= 1'b1; mul_ph_r <= 1'b0;
        if (cmd.op == akf_pkg::OP_DIV) begin
          if (!sts.s_pos) fault_r <= 1'b1;
          neg_r <= opa[DW-1];
          num_r <= NW'(opa[DW-1] ? -65'(opa) : 65'(opa)) << FRAC_BITS;
          den_r <= opb;
          quo_r <= '0; rem_r <= '0; cnt_r <= 6'(NW);
        end
      end else if (busy_r) begin
        unique case (op_r)
          akf_pkg::OP_ADD: begin
            rf_r[dst_r] <= akf_pkg::sat(66'(a_r) + 66'(b_r));
            busy_r <= 1'b0; done_r <= 1'b1;
          end
          akf_pkg::OP_SUB: begin
            rf_r[dst_r] <= akf_pkg::sat(66'(a_r) - 66'(b_r));
            busy_r <= 1'b0; done_r <= 1'b1;
          end
          akf_pkg::OP_MUL: begin
            if (!mul_ph_r) begin
              prod_r <= 64'(a_r) * 64'(b_r);
              mul_ph_r <= 1'b1;
            end else begin
              rf_r[dst_r] <= akf_pkg::sat(mres);
              busy_r <= 1'b0; done_r <= 1'b1;
            end
          end
          akf_pkg::OP_DIV: begin
            if (den_r[DW-1] || den_r == '0) begin
              rf_r[dst_r] <= '0;
              busy_r <= 1'b0; done_r <= 1'b1;
            end else if (cnt_r != 6'd0) begin
              num_r <= num_r << 1;
              cnt_r <= cnt_r - 6'd1;
              if (!rtry[NW]) begin
                rem_r <= rtry; quo_r <= {quo_r[NW-2:0], 1'b1};
              end else begin
                rem_r <= {rem_r[NW-1:0], num_r[NW-1]}; quo_r <= {quo_r[NW-2:0], 1'b0};
              end
            end else begin
              rf_r[dst_r] <= akf_pkg::sat(dres);
              busy_r <= 1'b0; done_r <= 1'b1;
            end
          end
          default: busy_r <= 1'b0;
        endcase
      end
      if (cmd.commit) begin
        rf_r[akf_pkg::R_P00] <= rf_r[akf_pkg::R_T2];
        angle_estimate <= rf_r[akf_pkg::R_X0];
        gain_fault     <= fault_r;
      end
      if (cmd.load) fault_r <= 1'b0;
    end
  end

  a_one_done: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("done held two cycles");
  a_go_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.go |-> !busy_r)
    else $error("issue while unit busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("done without work");

endmodule

### hdl/angle_kalman_filter_two_state.sv
// Two-state angle / gyro-bias Kalman filter.
// Input channel: in_valid / in_stall carrying in_gyro_rate and
// in_accel_angle (signed Q16.16). Result channel: out_valid / out_stall
// carrying out_angle_estimate and out_gain_fault.
// Configuration: cfg_we, cfg_index, cfg_data; write only while idle.
// One word is processed at a time. A step runs a 36-entry microprogram on
// one shared ALU: add/sub, multiply and the two divides (restoring, one
// quotient bit per cycle; data in Q16.16 at the default FRAC_BITS).
// The next word can be taken from the cycle after the result is delivered.
// The two divides are the longest operations of a step.
// Reset clears state to zero angle and bias, covariance to 66/197/197/197,
// and the registers to their reset values. While the receiver stalls,
// the result is held and no new word is accepted.
module angle_kalman_filter_two_state #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_gyro_rate,
  input  logic signed [31:0] in_accel_angle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_angle_estimate,
  output logic               out_gain_fault,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [30:0]        cfg_data
);

  logic [16:0] dt_r;
  logic [30:0] sz_r, qaa_r, qab_r, qba_r, qbb_r;
  akf_pkg::cmd_t cmd;
  akf_pkg::sts_t sts;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r <= 17'd655; sz_r <= 31'd5047; qaa_r <= 31'd66;
      qab_r <= 31'd197; qba_r <= 31'd197; qbb_r <= 31'd197;
    end else if (cfg_we) begin
      unique case (cfg_index)
        akf_pkg::REG_DT:  dt_r  <= cfg_data[16:0];
        akf_pkg::REG_SZ:  sz_r  <= cfg_data;
        akf_pkg::REG_QAA: qaa_r <= cfg_data;
        akf_pkg::REG_QAB: qab_r <= cfg_data;
        akf_pkg::REG_QBA: qba_r <= cfg_data;
        akf_pkg::REG_QBB: qbb_r <= cfg_data;
        default: ;
      endcase
    end
  end

  akf_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .cmd, .sts
  );

  akf_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst_n, .cmd, .sts, .in_gyro_rate, .in_accel_angle,
    .dt(dt_r), .sz(sz_r), .qaa(qaa_r), .qab(qab_r), .qba(qba_r), .qbb(qbb_r),
    .angle_estimate(out_angle_estimate), .gain_fault(out_gain_fault)
  );

endmodule
